// ===== hw/rtl/gni_pkg.sv =====
// ----------------------------------------------------------------------------
// gni_pkg
// shared types and codes of the grid neighbor index
// ----------------------------------------------------------------------------
package gni_pkg;

    localparam int COORD_W  = 24;
    localparam int ID_W     = 16;
    localparam int KEY_W    = 25;
    localparam int WK_W     = 26;
    localparam int PROD_W   = 40;
    localparam int INV_W    = 16;
    localparam int MAX_LIST = 16;
    localparam int LI_W     = 4;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    localparam logic [INV_W-1:0] INV_RESET = 16'd256;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic signed [COORD_W-1:0] old_x;
        logic signed [COORD_W-1:0] old_y;
        logic signed [COORD_W-1:0] old_z;
        logic [ID_W-1:0]           item_id;
    } req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic            moved;
        logic [ID_W-1:0] found_id;
        logic            id_valid;
        logic            last;
    } res_t;

endpackage

// ===== hw/rtl/gni_ram.sv =====
// ----------------------------------------------------------------------------
// gni_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module gni_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hw/rtl/grid_neighbor_index_core.sv =====
// ----------------------------------------------------------------------------
// grid_neighbor_index_core
// uniform grid spatial index, cell counts and cell rows held in rams
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// request   in         start & !busy         req (gni_pkg::req_t)
// result    out        res_valid, one cycle  res (gni_pkg::res_t)
// config    in         cfg_we                cfg_data (inv_cell_size)
//
// keys pass S_MUL then S_KEY per axis on one shared multiplier (3 or 6 axes)
// each visited cell takes a ram read in S_WALK and a modify/write in S_MOD,
// skipped update cells only S_WALK; add or remove visits the 3x3x3 block
// a query lists one id per cycle after its cell read
// after reset a clearing pass zeroes all GRID_DIM**3 cells of the count ram
// results cannot be stalled, busy stays high until the last result
// ----------------------------------------------------------------------------
module grid_neighbor_index_core #(
    parameter int GRID_DIM = 16,
    parameter int CELL_CAP = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  gni_pkg::req_t              req,
    output logic                       res_valid,
    output gni_pkg::res_t              res,
    input  logic                       cfg_we,
    input  logic [gni_pkg::INV_W-1:0]  cfg_data
);

    localparam int NCELL = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(NCELL);
    localparam int XW    = $clog2(GRID_DIM);
    localparam int RW    = CELL_CAP * gni_pkg::ID_W;
    localparam int CNT_W = $clog2(CELL_CAP + 1);
    localparam int SW    = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
    localparam int NW    = (CNT_W > 5) ? CNT_W : 5;
    localparam int KW    = gni_pkg::KEY_W;
    localparam int WW    = gni_pkg::WK_W;
    localparam logic signed [KW-1:0] K_LO = KW'(-(GRID_DIM / 2));
    localparam logic signed [KW-1:0] K_HI = KW'(GRID_DIM - 1 - (GRID_DIM / 2));
    localparam logic [WW-1:0] W_LO = WW'(-(GRID_DIM / 2));

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_KEY   = 9'b000001000,
        S_CHECK = 9'b000010000,
        S_WALK  = 9'b000100000,
        S_MOD   = 9'b001000000,
        S_LIST  = 9'b010000000,
        S_SPARE = 9'b100000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 clr_reg, clr_next;
    logic [gni_pkg::INV_W-1:0]     inv_reg, inv_next;
    gni_pkg::req_t                 req_reg, req_next;
    logic [2:0]                    idx_reg, idx_next;
    logic [gni_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic                          neg_reg, neg_next;
    logic signed [KW-1:0]          keys_reg [6];
    logic signed [KW-1:0]          keys_next [6];
    logic                          pass_reg, pass_next;
    logic [1:0]                    dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [AW-1:0]                 cell_reg, cell_next;
    logic                          full_reg, full_next, miss_reg, miss_next;
    logic [RW-1:0]                 row_reg, row_next;
    logic [NW-1:0]                 n_reg, n_next;
    logic [gni_pkg::LI_W-1:0]      li_reg, li_next;
    gni_pkg::res_t                 res_reg, res_next;
    logic                          res_valid_reg, res_valid_next;

    logic                          cnt_we, row_we;
    logic [AW-1:0]                 ram_addr;
    logic [CNT_W-1:0]              cnt_wdata, cnt_rd;
    logic [RW-1:0]                 row_wdata, row_rd;

    logic signed [gni_pkg::COORD_W-1:0] coord;
    logic [gni_pkg::COORD_W-1:0]   mag;
    logic [gni_pkg::COORD_W-1:0]   q;
    logic                          is_upd, is_query, adding, has_skip;
    logic signed [KW-1:0]          bx, by, bz, ox, oy, oz;
    logic [1:0]                    dxe, dye, dze;
    logic [WW-1:0]                 wx, wy, wz, fx, fy, fz;
    logic                          near, last_d;
    logic [AW-1:0]                 cell_comb;
    logic                          hit;
    logic [SW-1:0]                 hit_idx;
    logic                          kn_grid, kn_hood, ko_hood, keys_eq;
    logic [NW-1:0]                 cnt_w;

    gni_ram #(.WIDTH(CNT_W), .DEPTH(NCELL)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .addr  (ram_addr),
        .wdata (cnt_wdata),
        .rdata (cnt_rd)
    );

    gni_ram #(.WIDTH(RW), .DEPTH(NCELL)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .addr  (ram_addr),
        .wdata (row_wdata),
        .rdata (row_rd)
    );

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // key and walk datapath
    always_comb
    begin
        case (idx_reg)
            3'd0:    coord = req_reg.point_x;
            3'd1:    coord = req_reg.point_y;
            3'd2:    coord = req_reg.point_z;
            3'd3:    coord = req_reg.old_x;
            3'd4:    coord = req_reg.old_y;
            default: coord = req_reg.old_z;
        endcase
        mag = coord[gni_pkg::COORD_W-1] ? gni_pkg::COORD_W'(-coord) : coord;
        q   = gni_pkg::COORD_W'((prod_reg + gni_pkg::PROD_W'(32768)) >> 16);

        is_upd   = (req_reg.req_type == gni_pkg::REQ_UPDATE);
        is_query = (req_reg.req_type == gni_pkg::REQ_QUERY);
        adding   = (req_reg.req_type == gni_pkg::REQ_ADD) || (is_upd && pass_reg);
        has_skip = is_upd;
        if (is_upd && !pass_reg)
        begin
            bx = keys_reg[3]; by = keys_reg[4]; bz = keys_reg[5];
            ox = keys_reg[0]; oy = keys_reg[1]; oz = keys_reg[2];
        end
        else
        begin
            bx = keys_reg[0]; by = keys_reg[1]; bz = keys_reg[2];
            ox = keys_reg[3]; oy = keys_reg[4]; oz = keys_reg[5];
        end
        dxe = is_query ? 2'd1 : dx_reg;
        dye = is_query ? 2'd1 : dy_reg;
        dze = is_query ? 2'd1 : dz_reg;
        wx = {bx[KW-1], bx} + WW'(dxe) - WW'(1);
        wy = {by[KW-1], by} + WW'(dye) - WW'(1);
        wz = {bz[KW-1], bz} + WW'(dze) - WW'(1);
        fx = wx - {ox[KW-1], ox};
        fy = wy - {oy[KW-1], oy};
        fz = wz - {oz[KW-1], oz};
        near = (fx == '0 || fx == WW'(1) || fx == '1)
            && (fy == '0 || fy == WW'(1) || fy == '1)
            && (fz == '0 || fz == WW'(1) || fz == '1);
        cell_comb = AW'(XW'(wx - W_LO))
            + AW'(XW'(wy - W_LO)) * AW'(GRID_DIM)
            + AW'(XW'(wz - W_LO)) * AW'(GRID_DIM * GRID_DIM);
        last_d = is_query || (dx_reg == 2'd2 && dy_reg == 2'd2 && dz_reg == 2'd2);

        kn_grid = 1'b1;
        kn_hood = 1'b1;
        ko_hood = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (keys_reg[a] < K_LO || keys_reg[a] > K_HI)
                kn_grid = 1'b0;
            if (keys_reg[a] < K_LO + KW'(1) || keys_reg[a] > K_HI - KW'(1))
                kn_hood = 1'b0;
            if (keys_reg[a+3] < K_LO + KW'(1) || keys_reg[a+3] > K_HI - KW'(1))
                ko_hood = 1'b0;
        end
        keys_eq = (keys_reg[0] == keys_reg[3]) && (keys_reg[1] == keys_reg[4])
            && (keys_reg[2] == keys_reg[5]);

        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < CELL_CAP; i++)
        begin
            if (!hit && CNT_W'(i) < cnt_rd && row_rd[i*gni_pkg::ID_W +: gni_pkg::ID_W]
                == req_reg.item_id)
            begin
                hit     = 1'b1;
                hit_idx = SW'(i);
            end
        end
        cnt_w = NW'(cnt_rd);
    end

    // control
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        inv_next       = cfg_we ? cfg_data : inv_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        keys_next      = keys_reg;
        pass_next      = pass_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        cell_next      = cell_reg;
        full_next      = full_reg;
        miss_next      = miss_reg;
        row_next       = row_reg;
        n_next         = n_reg;
        li_next        = li_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        cnt_we         = 1'b0;
        row_we         = 1'b0;
        cnt_wdata      = cnt_rd;
        row_wdata      = row_rd;
        ram_addr       = cell_comb;

        case (state_reg)
            S_CLEAR:
            begin
                ram_addr  = clr_reg;
                cnt_we    = 1'b1;
                cnt_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(NCELL - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    idx_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = gni_pkg::PROD_W'(mag) * gni_pkg::PROD_W'(inv_reg);
                neg_next   = coord[gni_pkg::COORD_W-1];
                state_next = S_KEY;
            end
            S_KEY:
            begin
                keys_next[idx_reg] = neg_reg ? -KW'(q) : KW'(q);
                idx_next = idx_reg + 3'd1;
                if (idx_reg == (is_upd ? 3'd5 : 3'd2))
                    state_next = S_CHECK;
                else
                    state_next = S_MUL;
            end
            S_CHECK:
            begin
                pass_next = 1'b0;
                dx_next   = '0;
                dy_next   = '0;
                dz_next   = '0;
                full_next = 1'b0;
                miss_next = 1'b0;
                res_next  = '{status: gni_pkg::ST_OK, moved: 1'b0, found_id: '0,
                              id_valid: 1'b0, last: 1'b1};
                state_next = S_WALK;
                if (is_query)
                begin
                    if (!kn_grid)
                    begin
                        res_next.status = gni_pkg::ST_RANGE;
                        res_valid_next  = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (is_upd && keys_eq)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (!kn_hood || (is_upd && !ko_hood))
                begin
                    res_next.status = gni_pkg::ST_RANGE;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_WALK, S_MOD:
            begin
                if (state_reg == S_WALK && !(has_skip && near))
                begin
                    cell_next  = cell_comb;
                    state_next = S_MOD;
                end
                else
                begin
                    if (state_reg == S_MOD)
                    begin
                        ram_addr = cell_reg;
                        if (is_query)
                        begin
                            row_next = row_rd;
                            n_next   = (cnt_w > NW'(gni_pkg::MAX_LIST)) ?
                                       NW'(gni_pkg::MAX_LIST) : cnt_w;
                        end
                        else if (adding)
                        begin
                            if (cnt_rd >= CNT_W'(CELL_CAP))
                                full_next = 1'b1;
                            else
                            begin
                                row_wdata[SW'(cnt_rd)*gni_pkg::ID_W +: gni_pkg::ID_W] =
                                    req_reg.item_id;
                                row_we    = 1'b1;
                                cnt_wdata = cnt_rd + CNT_W'(1);
                                cnt_we    = 1'b1;
                            end
                        end
                        else if (!hit)
                            miss_next = 1'b1;
                        else
                        begin
                            row_wdata[hit_idx*gni_pkg::ID_W +: gni_pkg::ID_W] =
                                row_rd[SW'(cnt_rd - CNT_W'(1))*gni_pkg::ID_W +:
                                       gni_pkg::ID_W];
                            row_we    = 1'b1;
                            cnt_wdata = cnt_rd - CNT_W'(1);
                            cnt_we    = 1'b1;
                        end
                    end
                    state_next = S_WALK;
                    if (dz_reg != 2'd2)
                        dz_next = dz_reg + 2'd1;
                    else
                    begin
                        dz_next = '0;
                        if (dy_reg != 2'd2)
                            dy_next = dy_reg + 2'd1;
                        else
                        begin
                            dy_next = '0;
                            dx_next = dx_reg + 2'd1;
                        end
                    end
                    if (last_d)
                    begin
                        dx_next = '0;
                        dy_next = '0;
                        dz_next = '0;
                        if (is_query)
                        begin
                            li_next = '0;
                            if (cnt_rd == '0)
                            begin
                                res_valid_next = 1'b1;
                                state_next     = S_IDLE;
                            end
                            else
                                state_next = S_LIST;
                        end
                        else if (is_upd && !pass_reg)
                            pass_next = 1'b1;
                        else
                        begin
                            res_next.status = (miss_next) ? gni_pkg::ST_MISS :
                                              (full_next) ? gni_pkg::ST_FULL :
                                              gni_pkg::ST_OK;
                            res_next.moved  = is_upd;
                            res_valid_next  = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                end
            end
            S_LIST:
            begin
                res_next.status   = gni_pkg::ST_OK;
                res_next.moved    = 1'b0;
                res_next.found_id = row_reg[SW'(li_reg)*gni_pkg::ID_W +: gni_pkg::ID_W];
                res_next.id_valid = 1'b1;
                res_next.last     = (NW'(li_reg) == n_reg - NW'(1));
                res_valid_next    = 1'b1;
                li_next           = li_reg + gni_pkg::LI_W'(1);
                if (res_next.last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            inv_reg       <= gni_pkg::INV_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            inv_reg       <= inv_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        idx_reg  <= idx_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        keys_reg <= keys_next;
        pass_reg <= pass_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dz_reg   <= dz_next;
        cell_reg <= cell_next;
        full_reg <= full_next;
        miss_reg <= miss_next;
        row_reg  <= row_next;
        n_reg    <= n_next;
        li_reg   <= li_next;
        res_reg  <= res_next;
    end

endmodule

// ===== hw/rtl/gni_checker.sv =====
// ----------------------------------------------------------------------------
// gni_checker
// port level checks of the grid neighbor index
// ----------------------------------------------------------------------------
module gni_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      res_valid,
    input gni_pkg::res_t             res
);

    // accepted request holds busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low after transfer");

    // query list runs without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.last |=> res_valid)
        else $error("gap in result list");

    // a last result is not directly followed by another result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |=> !res_valid)
        else $error("result after last");

    // empty slot carries no id
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.id_valid |-> res.found_id == '0 && res.last)
        else $error("bad empty result");

    // moved flag never on a listed id or a range result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.moved |-> !res.id_valid && res.status != gni_pkg::ST_RANGE)
        else $error("bad moved flag");

endmodule

bind grid_neighbor_index_core gni_checker u_gni_checker (.*);

// ===== sim/tb_grid_neighbor_index_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_neighbor_index_core
// self-checking bench: directed table, a cell filled past capacity, then random
// add/remove/update/query traffic checked against a behavioral grid index held in the bench
// ----------------------------------------------------------------------------
module tb_grid_neighbor_index_core;

    localparam int GDIM  = 16;
    localparam int CCAP  = 16;
    localparam int NCELL = GDIM * GDIM * GDIM;
    localparam int HALF  = GDIM / 2;

    typedef struct {
        gni_pkg::req_t r;
        bit            has_want;
        gni_pkg::res_t want;
    } stim_row_t;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    gni_pkg::req_t  req;
    logic           res_valid;
    gni_pkg::res_t  res;
    logic           cfg_we;
    logic [15:0]    cfg_data;

    grid_neighbor_index_core #(.GRID_DIM(GDIM), .CELL_CAP(CCAP)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .res_valid (res_valid),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // bench copy of the index
    logic [15:0]    inv_scale;
    int             occupancy [NCELL];
    logic [15:0]    slots [NCELL][CCAP];
    gni_pkg::res_t  pending_results [$];
    stim_row_t      stim_rows [$];
    int             mismatches;
    int             checked;
    int             n_add, n_rem, n_upd, n_qry;
    logic           quiet;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #200ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input gni_pkg::res_t got,
                                   input gni_pkg::res_t want);
        begin
            mismatches++;
            $display("[%0t] %s: got %0d/%0d/%h/%0d/%0d want %0d/%0d/%h/%0d/%0d",
                $realtime, what, got.status, got.moved, got.found_id, got.id_valid,
                got.last, want.status, want.moved, want.found_id, want.id_valid,
                want.last);
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin
        gni_pkg::res_t want;
        if (rst_n && res_valid)
        begin
            if (pending_results.size() == 0)
            begin
                want = '0;
                report_mismatch("unexpected transfer", res, want);
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                if (res.status !== want.status)
                    report_mismatch("status", res, want);
                else if (res.moved !== want.moved)
                    report_mismatch("moved", res, want);
                else if (res.found_id !== want.found_id)
                    report_mismatch("found_id", res, want);
                else if (res.id_valid !== want.id_valid)
                    report_mismatch("id_valid", res, want);
                else if (res.last !== want.last)
                    report_mismatch("last", res, want);
            end
        end
    end

    function automatic longint cell_key(input logic signed [23:0] coord);
        longint c;
        longint mag;
        longint q;
        begin
            c   = coord;
            mag = (c < 0) ? -c : c;
            q   = (mag * longint'(inv_scale) + 64'h8000) >>> 16;
            return (c < 0) ? -q : q;
        end
    endfunction

    function automatic bit key_ok(input longint k);
        return k >= -HALF && k <= HALF - 1;
    endfunction

    function automatic bit hood_ok(input longint k [3]);
        for (int a = 0; a < 3; a++)
            if (!key_ok(k[a] - 1) || !key_ok(k[a] + 1))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int cell_num(input longint x, input longint y, input longint z);
        return int'((x + HALF) + (y + HALF) * GDIM + (z + HALF) * GDIM * GDIM) % NCELL;
    endfunction

    // add or remove id over the 3x3x3 block around k, skipping cells near avoid
    task automatic sweep_block(input longint k [3], input bit use_avoid,
                               input longint avoid [3], input bit adding,
                               input logic [15:0] id, inout bit full, inout bit miss);
        int  c;
        int  n;
        bit  hit;
        begin
            for (longint x = k[0] - 1; x <= k[0] + 1; x++)
                for (longint y = k[1] - 1; y <= k[1] + 1; y++)
                    for (longint z = k[2] - 1; z <= k[2] + 1; z++)
                    begin
                        if (use_avoid && x >= avoid[0] - 1 && x <= avoid[0] + 1
                            && y >= avoid[1] - 1 && y <= avoid[1] + 1
                            && z >= avoid[2] - 1 && z <= avoid[2] + 1)
                            continue;
                        c = cell_num(x, y, z);
                        n = occupancy[c];
                        if (adding)
                        begin
                            if (n >= CCAP)
                                full = 1'b1;
                            else
                            begin
                                slots[c][n] = id;
                                occupancy[c] = n + 1;
                            end
                        end
                        else
                        begin
                            hit = 1'b0;
                            for (int i = 0; i < n && !hit; i++)
                                if (slots[c][i] == id)
                                begin
                                    slots[c][i] = slots[c][n - 1];
                                    occupancy[c] = n - 1;
                                    hit = 1'b1;
                                end
                            if (!hit)
                                miss = 1'b1;
                        end
                    end
        end
    endtask

    function automatic gni_pkg::res_t make_res(input logic [1:0] st, input logic mv,
                                               input logic [15:0] id, input logic v,
                                               input logic l);
        gni_pkg::res_t r;
        r.status = st;
        r.moved = mv;
        r.found_id = id;
        r.id_valid = v;
        r.last = l;
        return r;
    endfunction

    // single closing result without an id
    function automatic gni_pkg::res_t done_res(input logic [1:0] st, input logic mv);
        return make_res(st, mv, 16'h0000, 1'b0, 1'b1);
    endfunction

    // compute expected results and apply the request to the bench index
    task automatic predict_index(input gni_pkg::req_t r, output gni_pkg::res_t outs [$]);
        longint kn [3];
        longint ko [3];
        bit     full;
        bit     miss;
        int     c;
        int     n;
        logic [1:0] st;
        begin
            outs = {};
            full = 1'b0;
            miss = 1'b0;
            kn[0] = cell_key(r.point_x);
            kn[1] = cell_key(r.point_y);
            kn[2] = cell_key(r.point_z);
            case (r.req_type)
                gni_pkg::REQ_QUERY:
                begin
                    n_qry++;
                    if (!key_ok(kn[0]) || !key_ok(kn[1]) || !key_ok(kn[2]))
                        outs = {outs, done_res(gni_pkg::ST_RANGE, 1'b0)};
                    else
                    begin
                        c = cell_num(kn[0], kn[1], kn[2]);
                        n = occupancy[c];
                        if (n > gni_pkg::MAX_LIST)
                            n = gni_pkg::MAX_LIST;
                        if (n == 0)
                            outs = {outs, done_res(gni_pkg::ST_OK, 1'b0)};
                        for (int i = 0; i < n; i++)
                            outs = {outs, make_res(gni_pkg::ST_OK, 1'b0, slots[c][i], 1'b1,
                                                   i == n - 1)};
                    end
                end
                gni_pkg::REQ_UPDATE:
                begin
                    n_upd++;
                    ko[0] = cell_key(r.old_x);
                    ko[1] = cell_key(r.old_y);
                    ko[2] = cell_key(r.old_z);
                    if (ko == kn)
                        outs = {outs, done_res(gni_pkg::ST_OK, 1'b0)};
                    else if (!hood_ok(ko) || !hood_ok(kn))
                        outs = {outs, done_res(gni_pkg::ST_RANGE, 1'b0)};
                    else
                    begin
                        sweep_block(ko, 1'b1, kn, 1'b0, r.item_id, full, miss);
                        sweep_block(kn, 1'b1, ko, 1'b1, r.item_id, full, miss);
                        st = miss ? gni_pkg::ST_MISS :
                             (full ? gni_pkg::ST_FULL : gni_pkg::ST_OK);
                        outs = {outs, done_res(st, 1'b1)};
                    end
                end
                default:
                begin
                    if (r.req_type == gni_pkg::REQ_ADD)
                        n_add++;
                    else
                        n_rem++;
                    if (!hood_ok(kn))
                        outs = {outs, done_res(gni_pkg::ST_RANGE, 1'b0)};
                    else
                    begin
                        sweep_block(kn, 1'b0, ko, r.req_type == gni_pkg::REQ_ADD,
                                    r.item_id, full, miss);
                        st = miss ? gni_pkg::ST_MISS :
                             (full ? gni_pkg::ST_FULL : gni_pkg::ST_OK);
                        outs = {outs, done_res(st, 1'b0)};
                    end
                end
            endcase
        end
    endtask

    // predict, optionally check the first result against a typed value, then drive
    task automatic send_request(input gni_pkg::req_t r, input bit has_want,
                                input gni_pkg::res_t want);
        gni_pkg::res_t outs [$];
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 5)) @(posedge clk);
            predict_index(r, outs);
            if (has_want && outs[0] !== want)
                report_mismatch("directed expectation", outs[0], want);
            foreach (outs[i])
                pending_results = {pending_results, outs[i]};
            start <= 1'b1;
            req   <= r;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            start <= 1'b0;
            req   <= '0;
            @(posedge clk);
        end
    endtask

    task automatic issue_request(input gni_pkg::req_t r);
        begin
            send_request(r, 1'b0, '0);
        end
    endtask

    task automatic add_row(input gni_pkg::req_t r, input bit has_want,
                           input gni_pkg::res_t want);
        stim_row_t row;
        begin
            row.r        = r;
            row.has_want = has_want;
            row.want     = want;
            stim_rows    = {stim_rows, row};
        end
    endtask

    task automatic drain_and_settle();
        int guard;
        begin
            guard = 0;
            while ((pending_results.size() != 0 || busy) && guard < 200000)
            begin
                @(posedge clk);
                guard++;
            end
            repeat (100) @(posedge clk);
        end
    endtask

    task automatic set_scale(input logic [15:0] v);
        begin
            drain_and_settle();
            cfg_we   <= 1'b1;
            cfg_data <= v;
            @(posedge clk);
            cfg_we   <= 1'b0;
            inv_scale = v;
            @(posedge clk);
        end
    endtask

    function automatic gni_pkg::req_t build_req(input logic [1:0] op, input int x,
                                                input int y, input int z, input int ox,
                                                input int oy, input int oz,
                                                input logic [15:0] id);
        gni_pkg::req_t r;
        r.req_type = op;
        r.point_x = 24'(x);
        r.point_y = 24'(y);
        r.point_z = 24'(z);
        r.old_x = 24'(ox);
        r.old_y = 24'(oy);
        r.old_z = 24'(oz);
        r.item_id = id;
        return r;
    endfunction

    // coordinate whose key at scale 256 lands near the middle, with random fraction
    function automatic int near_coord(input int span);
        return ($urandom_range(0, 2 * span) - span) * 256 + $urandom_range(0, 255) - 128;
    endfunction

    initial
    begin
        gni_pkg::req_t r;
        int            cx, cy, cz;
        logic [15:0]   ids [$];
        logic [15:0]   pick;

        mismatches = 0;
        checked = 0;
        n_add = 0;
        n_rem = 0;
        n_upd = 0;
        n_qry = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        inv_scale = gni_pkg::INV_RESET;
        for (int c = 0; c < NCELL; c++)
            occupancy[c] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        add_row(build_req(gni_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 16'h0000), 1'b1,
                done_res(gni_pkg::ST_OK, 1'b0));
        add_row(build_req(gni_pkg::REQ_QUERY, 8388607, 0, 0, 0, 0, 0, 16'h0000), 1'b1,
                done_res(gni_pkg::ST_RANGE, 1'b0));
        add_row(build_req(gni_pkg::REQ_QUERY, 0, -8388608, 0, 0, 0, 0, 16'h0000), 1'b1,
                done_res(gni_pkg::ST_RANGE, 1'b0));
        add_row(build_req(gni_pkg::REQ_ADD, 7 * 256, 0, 0, 0, 0, 0, 16'h1111), 1'b1,
                done_res(gni_pkg::ST_RANGE, 1'b0));
        add_row(build_req(gni_pkg::REQ_ADD, 0, 0, -7 * 256, 0, 0, 0, 16'hffff), 1'b1,
                done_res(gni_pkg::ST_OK, 1'b0));
        add_row(build_req(gni_pkg::REQ_ADD, 0, 0, 0, 0, 0, 0, 16'h0000), 1'b1,
                done_res(gni_pkg::ST_OK, 1'b0));
        add_row(build_req(gni_pkg::REQ_ADD, 128, 0, 0, 0, 0, 0, 16'h0000), 1'b0, '0);
        add_row(build_req(gni_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0, 16'h0000), 1'b0, '0);
        add_row(build_req(gni_pkg::REQ_REMOVE, 5 * 256, 5 * 256, 5 * 256, 0, 0, 0,
                          16'h1234), 1'b1, done_res(gni_pkg::ST_MISS, 1'b0));
        add_row(build_req(gni_pkg::REQ_REMOVE, -8388608, 0, 0, 0, 0, 0, 16'h0000), 1'b1,
                done_res(gni_pkg::ST_RANGE, 1'b0));
        add_row(build_req(gni_pkg::REQ_UPDATE, 100, 0, 0, -100, 0, 0, 16'h0000), 1'b1,
                done_res(gni_pkg::ST_OK, 1'b0));
        add_row(build_req(gni_pkg::REQ_UPDATE, 8388607, 8388607, 8388607,
                          8388607, 8388607, 8388607, 16'h0000), 1'b1,
                done_res(gni_pkg::ST_OK, 1'b0));
        add_row(build_req(gni_pkg::REQ_UPDATE, 7 * 256, 0, 0, 0, 0, 0, 16'h0000), 1'b1,
                done_res(gni_pkg::ST_RANGE, 1'b0));
        add_row(build_req(gni_pkg::REQ_UPDATE, 256, 0, 0, 0, 0, 0, 16'h0000), 1'b0, '0);
        add_row(build_req(gni_pkg::REQ_UPDATE, 3 * 256, 0, 0, 256, 0, 0, 16'h5555), 1'b1,
                done_res(gni_pkg::ST_MISS, 1'b1));
        add_row(build_req(gni_pkg::REQ_QUERY, 256, 0, 0, 0, 0, 0, 16'hffff), 1'b0, '0);
        add_row(build_req(gni_pkg::REQ_REMOVE, 0, 0, -7 * 256, 0, 0, 0, 16'hffff), 1'b1,
                done_res(gni_pkg::ST_OK, 1'b0));
        foreach (stim_rows[i])
            send_request(stim_rows[i].r, stim_rows[i].has_want, stim_rows[i].want);

        // fill the block around one cell past its capacity, then list that cell
        for (int i = 0; i < CCAP + 2; i++)
            issue_request(build_req(gni_pkg::REQ_ADD, -2 * 256, 2 * 256, 256, 0, 0, 0,
                                    16'(16'h0a00 + i)));
        issue_request(build_req(gni_pkg::REQ_QUERY, -2 * 256, 2 * 256, 256, 0, 0, 0,
                                16'h0000));
        issue_request(build_req(gni_pkg::REQ_UPDATE, 3 * 256, 2 * 256, 256,
                                -2 * 256, 2 * 256, 256, 16'h0a00));

        // random traffic over several scales
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_scale(16'd256);
                1: set_scale(16'd1);
                2: set_scale(16'hffff);
                3: set_scale(16'd128);
                default: set_scale(16'd256);
            endcase
            if (phase == 4)
                quiet = 1'b1;
            for (int n = 0; n < 80; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise with full-range fields
                    r = build_req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom, 16'($urandom));
                    issue_request(r);
                    continue;
                end
                if (phase == 2)
                begin
                    cx = $urandom_range(0, 2047) - 1024;
                    cy = $urandom_range(0, 2047) - 1024;
                    cz = $urandom_range(0, 2047) - 1024;
                    cx = cx / 4;
                    cy = cy / 4;
                    cz = cz / 4;
                end
                else if (phase == 1)
                begin
                    cx = $urandom_range(0, 2 * 6 * 65536) - 6 * 65536;
                    cy = $urandom_range(0, 2 * 6 * 65536) - 6 * 65536;
                    cz = $urandom_range(0, 2 * 6 * 65536) - 6 * 65536;
                end
                else
                begin
                    cx = near_coord(phase == 3 ? 12 : 6);
                    cy = near_coord(phase == 3 ? 12 : 6);
                    cz = near_coord(phase == 3 ? 12 : 6);
                end
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        pick = (ids.size() > 0 && $urandom_range(0, 3) == 0) ?
                            ids[$urandom_range(0, ids.size() - 1)] : 16'($urandom);
                        ids = {ids, pick};
                        issue_request(build_req(gni_pkg::REQ_ADD, cx, cy, cz, $urandom,
                                                $urandom, $urandom, pick));
                    end
                    3, 4:
                    begin
                        pick = (ids.size() > 0 && $urandom_range(0, 3) != 0) ?
                            ids[$urandom_range(0, ids.size() - 1)] : 16'($urandom);
                        issue_request(build_req(gni_pkg::REQ_REMOVE, cx, cy, cz, $urandom,
                                                $urandom, $urandom, pick));
                    end
                    5, 6:
                    begin
                        pick = (ids.size() > 0) ? ids[$urandom_range(0, ids.size() - 1)]
                                                : 16'($urandom);
                        issue_request(build_req(gni_pkg::REQ_UPDATE, cx, cy, cz,
                            cx + ($urandom_range(0, 4) - 2) * 256,
                            cy + ($urandom_range(0, 2) - 1) * 256,
                            cz + ($urandom_range(0, 2) - 1) * 128, pick));
                    end
                    default:
                        issue_request(build_req(gni_pkg::REQ_QUERY, cx, cy, cz, $urandom,
                                                $urandom, $urandom, 16'($urandom)));
                endcase
            end
        end
        set_scale(16'd0);
        issue_request(build_req(gni_pkg::REQ_QUERY, 8388607, -8388608, 12345, 0, 0, 0,
                                16'h0000));
        issue_request(build_req(gni_pkg::REQ_UPDATE, 8388607, 0, 0, -8388608, 0, 0,
                                16'h0007));

        drain_and_settle();
        $display("covered %0d add, %0d remove, %0d update, %0d query requests", n_add, n_rem,
                 n_upd, n_qry);
        $display("%0d results checked over six scale settings, %0d mismatches", checked,
                 mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
